// ===== hw/rtl/fcls_pkg.sv =====
// Shared types and constants for the four-connected line stepper.
package fcls_pkg;

	localparam int COORD_BITS = 12;
	localparam int COLOR_BITS = 24;
	// |cy*tx - ty*cx| stays below 2^(2*COORD_BITS+1)
	localparam int ERR_BITS   = 2 * COORD_BITS + 2;

	localparam logic [COLOR_BITS-1:0] COLOR_RESET = {COLOR_BITS{1'b1}};

	localparam logic KIND_BEGIN = 1'b0;
	localparam logic KIND_NEXT  = 1'b1;

	typedef logic [COORD_BITS-1:0]        coord_t;
	typedef logic signed [COORD_BITS:0]   delta_t;
	typedef logic signed [ERR_BITS-1:0]   err_t;
	typedef logic [COLOR_BITS-1:0]        color_t;

	typedef enum logic [1:0] {
		MODE_FLAT,
		MODE_UP,
		MODE_DOWN
	} mode_t;

	typedef enum logic [1:0] {
		ST_PIXEL,
		ST_ACCEPT,
		ST_REJECT,
		ST_IDLE
	} status_t;

	typedef struct packed {
		logic   kind;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} item_t;

	typedef struct packed {
		coord_t  pix_x;
		coord_t  pix_y;
		logic    last;
		status_t status;
	} result_t;

endpackage

// ===== hw/rtl/fcls_core.sv =====
// Segment state and combinational step logic with an incremental cross-product error term.
module fcls_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  fcls_pkg::item_t   item,
	output fcls_pkg::result_t result
);

	fcls_pkg::coord_t  target_x_q, target_y_q, cursor_x_q, cursor_y_q;
	fcls_pkg::coord_t  tx_q;
	fcls_pkg::delta_t  ty_q;
	fcls_pkg::err_t    err_q;
	fcls_pkg::mode_t   mode_q;
	logic              first_q, active_q;

	fcls_pkg::coord_t  target_x_n, target_y_n, cursor_x_n, cursor_y_n, tx_n;
	fcls_pkg::delta_t  ty_n;
	fcls_pkg::err_t    err_n, tx_ext, ty_ext;
	fcls_pkg::mode_t   mode_n;
	logic              first_n, active_n, err_le0, err_ge0, step_x, hit;

	// err = cy*tx - ty*cx, kept exact by adding on each step
	assign tx_ext  = {{(fcls_pkg::ERR_BITS-fcls_pkg::COORD_BITS){1'b0}}, tx_q};
	assign ty_ext  = {{(fcls_pkg::ERR_BITS-fcls_pkg::COORD_BITS-1){ty_q[fcls_pkg::COORD_BITS]}}, ty_q};
	assign err_le0 = err_q[fcls_pkg::ERR_BITS-1] || (err_q == '0);
	assign err_ge0 = !err_q[fcls_pkg::ERR_BITS-1];

	always_comb begin
		target_x_n = target_x_q;
		target_y_n = target_y_q;
		cursor_x_n = cursor_x_q;
		cursor_y_n = cursor_y_q;
		tx_n       = tx_q;
		ty_n       = ty_q;
		err_n      = err_q;
		mode_n     = mode_q;
		first_n    = first_q;
		active_n   = active_q;
		step_x     = 1'b0;
		hit        = 1'b0;
		result     = '0;
		result.status = fcls_pkg::ST_IDLE;
		if (item.kind == fcls_pkg::KIND_BEGIN) begin
			if (item.end_x <= item.start_x) begin
				active_n      = 1'b0;
				result.status = fcls_pkg::ST_REJECT;
			end else begin
				target_x_n = item.end_x;
				target_y_n = item.end_y;
				cursor_x_n = item.start_x;
				cursor_y_n = item.start_y;
				tx_n       = item.end_x - item.start_x;
				ty_n       = $signed({1'b0, item.end_y}) - $signed({1'b0, item.start_y});
				err_n      = '0;
				if (item.end_y < item.start_y)
					mode_n = fcls_pkg::MODE_UP;
				else if (item.end_y > item.start_y)
					mode_n = fcls_pkg::MODE_DOWN;
				else
					mode_n = fcls_pkg::MODE_FLAT;
				first_n       = (item.end_y != item.start_y);
				active_n      = 1'b1;
				result.status = fcls_pkg::ST_ACCEPT;
			end
		end else if (active_q) begin
			case (mode_q)
				fcls_pkg::MODE_UP: begin
					if (first_q) begin
						cursor_x_n = cursor_x_q + 1'b1;
						cursor_y_n = cursor_y_q - 1'b1;
						err_n      = err_q - ty_ext - tx_ext;
						first_n    = 1'b0;
					end else begin
						step_x = err_le0;
						if (step_x) begin
							cursor_x_n = cursor_x_q + 1'b1;
							err_n      = err_q - ty_ext;
						end else begin
							cursor_y_n = cursor_y_q - 1'b1;
							err_n      = err_q - tx_ext;
						end
					end
				end
				fcls_pkg::MODE_DOWN: begin
					if (first_q) begin
						cursor_x_n = cursor_x_q + 1'b1;
						cursor_y_n = cursor_y_q + 1'b1;
						err_n      = err_q - ty_ext + tx_ext;
						first_n    = 1'b0;
					end else begin
						step_x = err_ge0;
						if (step_x) begin
							cursor_x_n = cursor_x_q + 1'b1;
							err_n      = err_q - ty_ext;
						end else begin
							cursor_y_n = cursor_y_q + 1'b1;
							err_n      = err_q + tx_ext;
						end
					end
				end
				default: begin
					cursor_x_n = cursor_x_q + 1'b1;
				end
			endcase
			hit           = (cursor_x_n == target_x_q) && (cursor_y_n == target_y_q);
			active_n      = !hit;
			result.pix_x  = cursor_x_n;
			result.pix_y  = cursor_y_n;
			result.last   = hit;
			result.status = fcls_pkg::ST_PIXEL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0;
			target_y_q <= '0;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			tx_q       <= '0;
			ty_q       <= '0;
			err_q      <= '0;
			mode_q     <= fcls_pkg::MODE_FLAT;
			first_q    <= 1'b0;
			active_q   <= 1'b0;
		end else if (step_en) begin
			target_x_q <= target_x_n;
			target_y_q <= target_y_n;
			cursor_x_q <= cursor_x_n;
			cursor_y_q <= cursor_y_n;
			tx_q       <= tx_n;
			ty_q       <= ty_n;
			err_q      <= err_n;
			mode_q     <= mode_n;
			first_q    <= first_n;
			active_q   <= active_n;
		end
	end

endmodule

// ===== hw/rtl/four_connected_line_stepper.sv =====
// Top level of the four-connected line stepper: input register, step core, result register.
// Takes one beat per clock while in_stall is low and gives one result beat per input beat, via
// the input register, the step core and the result register. The combinational cursor update,
// one add and a sign test on the slope error term, sets the rate. A begin beat answers accepted
// or rejected; each next beat answers one pixel, or no active segment. pixel_color resets to all
// ones; the user must write it by cfg_wr_en/cfg_wr_data only while idle, unchecked by the block.
module four_connected_line_stepper (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [23:0]                cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  fcls_pkg::coord_t           start_x,
	input  fcls_pkg::coord_t           start_y,
	input  fcls_pkg::coord_t           end_x,
	input  fcls_pkg::coord_t           end_y,
	output logic                       out_valid,
	input  logic                       out_stall,
	output fcls_pkg::coord_t           pix_x,
	output fcls_pkg::coord_t           pix_y,
	output logic [23:0]                pix_color,
	output logic                       last,
	output logic [1:0]                 status
);

	fcls_pkg::color_t  pixel_color_q;
	fcls_pkg::item_t   item_s1;
	logic              valid_s1;
	fcls_pkg::result_t res, res_q;
	fcls_pkg::color_t  color_q;
	logic              out_valid_q, advance, step_en;

	assign advance  = !out_valid_q || !out_stall;
	assign step_en  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pixel_color_q <= fcls_pkg::COLOR_RESET;
		else if (cfg_wr_en)
			pixel_color_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= '{kind: kind, start_x: start_x, start_y: start_y,
				end_x: end_x, end_y: end_y};
	end

	fcls_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.item    (item_s1),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			res_q   <= res;
			color_q <= (res.status == fcls_pkg::ST_PIXEL) ? pixel_color_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign pix_x     = res_q.pix_x;
	assign pix_y     = res_q.pix_y;
	assign pix_color = color_q;
	assign last      = res_q.last;
	assign status    = res_q.status;

endmodule
